### hw/rtl/sah_split_search_top_macros.svh
// Shared assertion macros for the split search block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SAH_SPLIT_SEARCH_TOP_MACROS_SVH
`define SAH_SPLIT_SEARCH_TOP_MACROS_SVH

// Same-cycle implication check.
`define SAH_CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sah_split_search: same-cycle check failed");

// Next-cycle implication check.
`define SAH_CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sah_split_search: next-cycle check failed");

`endif

### hw/rtl/sah_pkg.sv
`timescale 1ns / 1ps

package sah_pkg;

  localparam int MAX_BOXES  = 256;
  localparam int COORD_BITS = 16;
  localparam int AW         = $clog2(MAX_BOXES);
  localparam int CW         = AW + 1;
  localparam int EXT_W      = COORD_BITS;
  localparam int PROD_W     = 2 * COORD_BITS;
  localparam int AREA_W     = PROD_W + 3;
  localparam int NUM_W      = AREA_W + CW;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_W      = NUM_W + FRAC_BITS;
  localparam int KW         = $clog2(DIV_W);
  localparam int KEY_W      = COORD_BITS + 1;
  localparam int POS_W      = 18;
  localparam int COST_W     = 25;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_SPLIT_AXIS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THREE_DIM  = 2'd1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] lo_x;
    logic signed [COORD_BITS-1:0] lo_y;
    logic signed [COORD_BITS-1:0] lo_z;
    logic signed [COORD_BITS-1:0] hi_x;
    logic signed [COORD_BITS-1:0] hi_y;
    logic signed [COORD_BITS-1:0] hi_z;
  } box_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_START,
    OP_RK_RDI, OP_RK_KI, OP_RK_RDJ, OP_RK_CMP, OP_RK_WR,
    OP_SF_INIT, OP_SF_ORD, OP_SF_BOX, OP_SF_MRG,
    OP_AR_EXT, OP_AR_P0, OP_AR_P1, OP_AR_P2, OP_AR_SUM,
    OP_SW_INIT, OP_SW_ORD, OP_SW_BOX, OP_SW_GET, OP_SW_FIRST,
    OP_NUM0, OP_NUM1, OP_CMP, OP_SW_NEXT,
    OP_DV_INIT, OP_DV_STEP, OP_EMIT, OP_EMIT_NS
  } dp_op_t;

  typedef enum logic [1:0] {
    CTX_AP, CTX_AL, CTX_AR
  } area_ctx_t;

  typedef struct packed {
    dp_op_t    op;
    area_ctx_t ctx;
  } dp_cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic i_last;
    logic i_zero;
    logic j_last;
    logic k_zero;
    logic ap_zero;
    logic out_free;
  } dp_sts_t;

  // Centroid sum of a box on one axis.
  function automatic logic signed [KEY_W-1:0] box_key(input box_t b, input logic [1:0] ax);
    logic signed [KEY_W-1:0] k;
    case (ax)
      2'd0:    k = {b.lo_x[COORD_BITS-1], b.lo_x} + {b.hi_x[COORD_BITS-1], b.hi_x};
      2'd1:    k = {b.lo_y[COORD_BITS-1], b.lo_y} + {b.hi_y[COORD_BITS-1], b.hi_y};
      default: k = {b.lo_z[COORD_BITS-1], b.lo_z} + {b.hi_z[COORD_BITS-1], b.hi_z};
    endcase
    return k;
  endfunction

  // Union of two boxes.
  function automatic box_t box_merge(input box_t a, input box_t b);
    box_t m;
    m.lo_x = (b.lo_x < a.lo_x) ? b.lo_x : a.lo_x;
    m.lo_y = (b.lo_y < a.lo_y) ? b.lo_y : a.lo_y;
    m.lo_z = (b.lo_z < a.lo_z) ? b.lo_z : a.lo_z;
    m.hi_x = (b.hi_x > a.hi_x) ? b.hi_x : a.hi_x;
    m.hi_y = (b.hi_y > a.hi_y) ? b.hi_y : a.hi_y;
    m.hi_z = (b.hi_z > a.hi_z) ? b.hi_z : a.hi_z;
    return m;
  endfunction

  // Extent of one axis; a negative extent counts as zero.
  function automatic logic [EXT_W-1:0] box_ext(input logic signed [COORD_BITS-1:0] lo,
                                               input logic signed [COORD_BITS-1:0] hi);
    logic [COORD_BITS:0] d;
    d = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
    return d[COORD_BITS] ? '0 : d[EXT_W-1:0];
  endfunction

endpackage

### hw/rtl/sah_ram.sv
`timescale 1ns / 1ps

module sah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sah_ctrl.sv
`timescale 1ns / 1ps

module sah_ctrl
  import sah_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last_box,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_NCHK,
    S_RK_RDI, S_RK_KI, S_RK_RDJ, S_RK_CMP, S_RK_WR,
    S_SF_INIT, S_SF_ORD, S_SF_BOX, S_SF_MRG,
    S_AR_EXT, S_AR_P0, S_AR_P1, S_AR_P2, S_AR_SUM, S_AP_CHK,
    S_SW_INIT, S_SW_ORD, S_SW_BOX, S_SW_GET, S_SW_FIRST,
    S_NUM0, S_NUM1, S_CMP, S_SW_NEXT,
    S_DV_INIT, S_DV_STEP, S_EMIT, S_EMIT_NS
  } state_t;

  state_t    state_r;
  area_ctx_t ctx_r;

  // Boxes are taken only while the block waits for a set.
  assign in_stall = (state_r != S_IDLE);

  // State register and the area context that selects where an area goes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctx_r   <= CTX_AP;
    end else begin
      unique case (state_r)
        S_IDLE:     if (in_valid && in_last_box) state_r <= S_START;
        S_START:    state_r <= S_NCHK;
        S_NCHK:     state_r <= sts.n_lt2 ? S_EMIT_NS : S_RK_RDI;
        S_RK_RDI:   state_r <= S_RK_KI;
        S_RK_KI:    state_r <= S_RK_RDJ;
        S_RK_RDJ:   state_r <= S_RK_CMP;
        S_RK_CMP:   state_r <= sts.j_last ? S_RK_WR : S_RK_RDJ;
        S_RK_WR:    state_r <= sts.i_last ? S_SF_INIT : S_RK_RDI;
        S_SF_INIT:  state_r <= S_SF_ORD;
        S_SF_ORD:   state_r <= S_SF_BOX;
        S_SF_BOX:   state_r <= S_SF_MRG;
        S_SF_MRG: begin
          if (sts.i_zero) begin
            ctx_r   <= CTX_AP;
            state_r <= S_AR_EXT;
          end else begin
            state_r <= S_SF_ORD;
          end
        end
        S_AR_EXT:   state_r <= S_AR_P0;
        S_AR_P0:    state_r <= S_AR_P1;
        S_AR_P1:    state_r <= S_AR_P2;
        S_AR_P2:    state_r <= S_AR_SUM;
        S_AR_SUM: begin
          unique case (ctx_r)
            CTX_AP: state_r <= S_AP_CHK;
            CTX_AL: begin
              ctx_r   <= CTX_AR;
              state_r <= S_AR_EXT;
            end
            default: state_r <= S_NUM0;
          endcase
        end
        S_AP_CHK:   state_r <= sts.ap_zero ? S_EMIT_NS : S_SW_INIT;
        S_SW_INIT:  state_r <= S_SW_ORD;
        S_SW_ORD:   state_r <= S_SW_BOX;
        S_SW_BOX:   state_r <= S_SW_GET;
        S_SW_GET: begin
          if (sts.i_zero) begin
            state_r <= S_SW_FIRST;
          end else begin
            ctx_r   <= CTX_AL;
            state_r <= S_AR_EXT;
          end
        end
        S_SW_FIRST: state_r <= S_SW_ORD;
        S_NUM0:     state_r <= S_NUM1;
        S_NUM1:     state_r <= S_CMP;
        S_CMP:      state_r <= S_SW_NEXT;
        S_SW_NEXT:  state_r <= sts.i_last ? S_DV_INIT : S_SW_ORD;
        S_DV_INIT:  state_r <= S_DV_STEP;
        S_DV_STEP:  state_r <= sts.k_zero ? S_EMIT : S_DV_STEP;
        S_EMIT:     if (sts.out_free) state_r <= S_IDLE;
        S_EMIT_NS:  if (sts.out_free) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  // Command decode for the datapath.
  always_comb begin
    cmd.ctx = ctx_r;
    unique case (state_r)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NOP;
      S_START:    cmd.op = OP_START;
      S_RK_RDI:   cmd.op = OP_RK_RDI;
      S_RK_KI:    cmd.op = OP_RK_KI;
      S_RK_RDJ:   cmd.op = OP_RK_RDJ;
      S_RK_CMP:   cmd.op = OP_RK_CMP;
      S_RK_WR:    cmd.op = OP_RK_WR;
      S_SF_INIT:  cmd.op = OP_SF_INIT;
      S_SF_ORD:   cmd.op = OP_SF_ORD;
      S_SF_BOX:   cmd.op = OP_SF_BOX;
      S_SF_MRG:   cmd.op = OP_SF_MRG;
      S_AR_EXT:   cmd.op = OP_AR_EXT;
      S_AR_P0:    cmd.op = OP_AR_P0;
      S_AR_P1:    cmd.op = OP_AR_P1;
      S_AR_P2:    cmd.op = OP_AR_P2;
      S_AR_SUM:   cmd.op = OP_AR_SUM;
      S_SW_INIT:  cmd.op = OP_SW_INIT;
      S_SW_ORD:   cmd.op = OP_SW_ORD;
      S_SW_BOX:   cmd.op = OP_SW_BOX;
      S_SW_GET:   cmd.op = OP_SW_GET;
      S_SW_FIRST: cmd.op = OP_SW_FIRST;
      S_NUM0:     cmd.op = OP_NUM0;
      S_NUM1:     cmd.op = OP_NUM1;
      S_CMP:      cmd.op = OP_CMP;
      S_SW_NEXT:  cmd.op = OP_SW_NEXT;
      S_DV_INIT:  cmd.op = OP_DV_INIT;
      S_DV_STEP:  cmd.op = OP_DV_STEP;
      S_EMIT:     cmd.op = OP_EMIT;
      S_EMIT_NS:  cmd.op = OP_EMIT_NS;
      default:    cmd.op = OP_NOP;
    endcase
  end

endmodule

### hw/rtl/sah_dp.sv
`timescale 1ns / 1ps
`include "sah_split_search_top_macros.svh"

module sah_dp
  import sah_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_sts_t                      sts,
  input  logic signed [COORD_BITS-1:0] in_min_x,
  input  logic signed [COORD_BITS-1:0] in_min_y,
  input  logic signed [COORD_BITS-1:0] in_min_z,
  input  logic signed [COORD_BITS-1:0] in_max_x,
  input  logic signed [COORD_BITS-1:0] in_max_y,
  input  logic signed [COORD_BITS-1:0] in_max_z,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_no_split,
  output logic [COST_W-1:0]            out_best_cost_q16,
  output logic signed [POS_W-1:0]      out_split_pos_q2,
  output logic                         out_overflow
);

  logic [1:0]               split_axis_r;
  logic                     three_dim_r;
  logic [1:0]               axis_eff;
  logic [CW-1:0]            cnt_r, n_r, i_r, j_r;
  logic                     ovf_seen_r, ovf_res_r, out_valid_r, found_r, first_r;
  logic [AW-1:0]            rank_r;
  logic signed [KEY_W-1:0]  key_i_r, key_cur_r, prev_key_r, key_rd;
  box_t                     left_r, cur_r, suf_r, box_rd, suf_rd, box_in, mrg, area_src;
  logic [AW-1:0]            ord_rd, box_raddr;
  logic [EXT_W-1:0]         ex_r, ey_r, ez_r;
  logic [PROD_W-1:0]        p0_r, p1_r, p2_r;
  logic [AREA_W-1:0]        ap_r, al_r, ar_r, area_sum, rem_r;
  logic [NUM_W-1:0]         num_r, best_r, mul_l, mul_r;
  logic [POS_W-1:0]         pos_r;
  logic [DIV_W-1:0]         quo_r, dvd;
  logic [KW-1:0]            k_r;
  logic [AREA_W:0]          r2;
  logic [DIV_W:0]           cost_full;
  logic [COST_W-1:0]        cost_sat;
  logic                     out_free, box_we;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_axis_r <= 2'd0;
      three_dim_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SPLIT_AXIS: split_axis_r <= cfg_wdata[1:0];
        REG_THREE_DIM:  three_dim_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Axis 3 folds onto z; in 2D mode z folds onto y.
  always_comb begin
    axis_eff = split_axis_r;
    if (axis_eff == 2'd3) axis_eff = 2'd2;
    if (!three_dim_r && axis_eff[1]) axis_eff = 2'd1;
  end

  // Box, sorted-order and suffix stores.
  assign box_in = '{lo_x: in_min_x, lo_y: in_min_y, lo_z: in_min_z,
                    hi_x: in_max_x, hi_y: in_max_y, hi_z: in_max_z};
  assign box_we = (cmd.op == OP_LOAD) && (cnt_r < CW'(MAX_BOXES));

  always_comb begin
    case (cmd.op)
      OP_RK_RDI: box_raddr = i_r[AW-1:0];
      OP_RK_RDJ: box_raddr = j_r[AW-1:0];
      default:   box_raddr = ord_rd;
    endcase
  end

  sah_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk(clk), .we(box_we), .waddr(cnt_r[AW-1:0]), .wdata(box_in),
    .raddr(box_raddr), .rdata(box_rd)
  );

  sah_ram #(.WIDTH(AW), .DEPTH(MAX_BOXES)) u_ord_ram (
    .clk(clk), .we(cmd.op == OP_RK_WR), .waddr(rank_r), .wdata(i_r[AW-1:0]),
    .raddr(i_r[AW-1:0]), .rdata(ord_rd)
  );

  assign mrg = first_r ? box_rd : box_merge(left_r, box_rd);

  sah_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_suf_ram (
    .clk(clk), .we(cmd.op == OP_SF_MRG), .waddr(i_r[AW-1:0]), .wdata(mrg),
    .raddr(i_r[AW-1:0]), .rdata(suf_rd)
  );

  // Combinational helpers for the arithmetic steps.
  assign key_rd    = box_key(box_rd, axis_eff);
  assign area_src  = (cmd.ctx == CTX_AR) ? suf_r : left_r;
  assign area_sum  = three_dim_r ?
                     {(AREA_W-1)'(p0_r) + (AREA_W-1)'(p1_r) + (AREA_W-1)'(p2_r), 1'b0} :
                     AREA_W'(p0_r);
  assign mul_l     = NUM_W'(al_r) * NUM_W'(i_r);
  assign mul_r     = NUM_W'(ar_r) * NUM_W'(n_r - i_r);
  assign dvd       = {best_r, {FRAC_BITS{1'b0}}};
  assign r2        = {rem_r, dvd[k_r]};
  assign cost_full = {1'b0, quo_r} + (DIV_W+1)'(1 << FRAC_BITS);
  assign cost_sat  = (cost_full > (DIV_W+1)'({COST_W{1'b1}})) ? {COST_W{1'b1}} :
                     cost_full[COST_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;

  // Control state: box count, overflow flag and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD) begin
        if (cnt_r < CW'(MAX_BOXES)) cnt_r <= cnt_r + 1'b1;
        else ovf_seen_r <= 1'b1;
      end else if (cmd.op == OP_START) begin
        cnt_r      <= '0;
        ovf_seen_r <= 1'b0;
      end
      if ((cmd.op == OP_EMIT || cmd.op == OP_EMIT_NS) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the sort, sweep and divide.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        n_r       <= cnt_r;
        ovf_res_r <= ovf_seen_r;
        i_r       <= '0;
      end
      OP_RK_KI: begin
        key_i_r <= key_rd;
        rank_r  <= '0;
        j_r     <= '0;
      end
      OP_RK_CMP: begin
        if (key_rd < key_i_r || (key_rd == key_i_r && j_r < i_r)) rank_r <= rank_r + 1'b1;
        j_r <= j_r + 1'b1;
      end
      OP_RK_WR:   i_r <= i_r + 1'b1;
      OP_SF_INIT: begin
        i_r     <= n_r - 1'b1;
        first_r <= 1'b1;
      end
      OP_SF_MRG: begin
        left_r  <= mrg;
        first_r <= 1'b0;
        if (i_r != '0) i_r <= i_r - 1'b1;
      end
      OP_AR_EXT: begin
        ex_r <= box_ext(area_src.lo_x, area_src.hi_x);
        ey_r <= box_ext(area_src.lo_y, area_src.hi_y);
        ez_r <= box_ext(area_src.lo_z, area_src.hi_z);
      end
      OP_AR_P0: p0_r <= PROD_W'(ex_r) * PROD_W'(ey_r);
      OP_AR_P1: p1_r <= PROD_W'(ex_r) * PROD_W'(ez_r);
      OP_AR_P2: p2_r <= PROD_W'(ey_r) * PROD_W'(ez_r);
      OP_AR_SUM: begin
        case (cmd.ctx)
          CTX_AP:  ap_r <= area_sum;
          CTX_AL:  al_r <= area_sum;
          default: ar_r <= area_sum;
        endcase
      end
      OP_SW_INIT: begin
        i_r     <= '0;
        found_r <= 1'b0;
      end
      OP_SW_GET: begin
        cur_r     <= box_rd;
        key_cur_r <= key_rd;
        suf_r     <= suf_rd;
      end
      OP_SW_FIRST: begin
        left_r     <= cur_r;
        prev_key_r <= key_cur_r;
        i_r        <= i_r + 1'b1;
      end
      OP_NUM0: num_r <= mul_l;
      OP_NUM1: num_r <= num_r + mul_r;
      OP_CMP: begin
        // First strict minimum wins.
        if (!found_r || num_r < best_r) begin
          found_r <= 1'b1;
          best_r  <= num_r;
          pos_r   <= {prev_key_r[KEY_W-1], prev_key_r} + {key_cur_r[KEY_W-1], key_cur_r};
        end
      end
      OP_SW_NEXT: begin
        left_r     <= box_merge(left_r, cur_r);
        prev_key_r <= key_cur_r;
        i_r        <= i_r + 1'b1;
      end
      OP_DV_INIT: begin
        rem_r <= '0;
        quo_r <= '0;
        k_r   <= KW'(DIV_W - 1);
      end
      OP_DV_STEP: begin
        // Restoring division, one quotient bit per cycle.
        if (r2 >= {1'b0, ap_r}) begin
          rem_r <= AREA_W'(r2 - {1'b0, ap_r});
          quo_r <= {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= r2[AREA_W-1:0];
          quo_r <= {quo_r[DIV_W-2:0], 1'b0};
        end
        k_r <= k_r - 1'b1;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_no_split      <= 1'b0;
          out_best_cost_q16 <= cost_sat;
          out_split_pos_q2  <= pos_r;
          out_overflow      <= ovf_res_r;
        end
      end
      OP_EMIT_NS: begin
        if (out_free) begin
          out_no_split      <= 1'b1;
          out_best_cost_q16 <= '0;
          out_split_pos_q2  <= '0;
          out_overflow      <= ovf_res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  // Status back to the controller.
  assign sts.n_lt2    = (n_r < CW'(2));
  assign sts.i_last   = (i_r == n_r - 1'b1);
  assign sts.i_zero   = (i_r == '0);
  assign sts.j_last   = (j_r == n_r - 1'b1);
  assign sts.k_zero   = (k_r == '0);
  assign sts.ap_zero  = (ap_r == '0);
  assign sts.out_free = out_free;

  `SAH_CHK_IMP(a_cnt_cap, 1'b1, cnt_r <= CW'(MAX_BOXES))
  `SAH_CHK_NXT(a_start_clears, cmd.op == OP_START, cnt_r == '0 && !ovf_seen_r)
  `SAH_CHK_IMP(a_rem_below_ap, cmd.op == OP_DV_STEP, rem_r < ap_r)

endmodule

### hw/rtl/sah_split_search_top.sv
// Boxes are loaded while the block is idle; the box with last_box set starts evaluation.
// The rank sort sweeps the box memory once per box, the cost sweep forms box areas
// from 16x16 extent products, and a restoring divider yields one quotient bit per
// cycle. One set at a time.
// Synchronous active-low reset empties the box count, clears overflow and restores
// split_axis 0 and 3D mode; the box memories are not cleared.
`timescale 1ns / 1ps

module sah_split_search_top
  import sah_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_min_x,
  input  logic signed [COORD_BITS-1:0] in_min_y,
  input  logic signed [COORD_BITS-1:0] in_min_z,
  input  logic signed [COORD_BITS-1:0] in_max_x,
  input  logic signed [COORD_BITS-1:0] in_max_y,
  input  logic signed [COORD_BITS-1:0] in_max_z,
  input  logic                         in_last_box,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_no_split,
  output logic [COST_W-1:0]            out_best_cost_q16,
  output logic signed [POS_W-1:0]      out_split_pos_q2,
  output logic                         out_overflow,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer.
  sah_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last_box(in_last_box),
    .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  // Stores, arithmetic and result register.
  sah_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_min_x(in_min_x), .in_min_y(in_min_y), .in_min_z(in_min_z),
    .in_max_x(in_max_x), .in_max_y(in_max_y), .in_max_z(in_max_z),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall), .out_no_split(out_no_split),
    .out_best_cost_q16(out_best_cost_q16), .out_split_pos_q2(out_split_pos_q2),
    .out_overflow(out_overflow)
  );

endmodule
